/* src/pid_aw_pkg.sv */
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Shared types and constants for the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W = 3;

    // time_step at or below this raw value (about 1 us) disables the D term
    localparam logic [DATA_W-1:0] DT_MIN_RAW = 32'd4295;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_LIMIT = 3'd3,
        CFG_OUT_LIMIT   = 3'd4,
        CFG_TIME_STEP   = 3'd5
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_DT,
        S_ACC,
        S_MUL_I,
        S_D_SETUP,
        S_DIV,
        S_RATE,
        S_MUL_D,
        S_D_TERM,
        S_SUM,
        S_DONE
    } t_state;

endpackage

/* src/pid_controller_anti_windup_unit.sv */
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_unit
// PID step engine: one shared 33x33 multiplier and a restoring divider
// under a small sequencer, integral clamp and output clamp.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | i_mode, i_target, i_measured              | i_valid / o_ready
//  out     | o_drive, o_out_clamped, o_integ_clamped   | o_valid / i_ready
//  config  | i_cfg_addr, i_cfg_wdata                   | i_cfg_wr_en
//
//  A compute word runs its steps on the shared multiplier and, when the D term
//  divides, the one-bit-per-cycle divider; the divide is skipped when the
//  error change is at least time_step (rate saturates), the D term when
//  time_step is 4295 or less, and a clear word (mode 1) goes to the result.
//  o_ready is high only while the sequencer is idle; the result register
//  lets the next word start while a result waits, and the sequencer holds
//  in its last state until that register frees.
//  Reset (synchronous, active low) clears state, integral and last error.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config
    input  logic                                  i_cfg_wr_en,
    input  logic [pid_aw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pid_aw_pkg::DATA_W-1:0]         i_cfg_wdata,
    // input words
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic signed [pid_aw_pkg::DATA_W-1:0]  i_target,
    input  logic signed [pid_aw_pkg::DATA_W-1:0]  i_measured,
    // result words
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [pid_aw_pkg::DATA_W-1:0]  o_drive,
    output logic                                  o_out_clamped,
    output logic                                  o_integ_clamped
);

    localparam int W = pid_aw_pkg::DATA_W;

    // saturate a 64-bit value to the signed 32-bit range
    function automatic logic signed [W-1:0] sat64(input logic signed [2*W-1:0] v);
        logic [W:0] top;
        top = v[2*W-1:W-1];
        if ((&top) || (~|top)) begin
            return v[W-1:0];
        end else if (v[2*W-1]) begin
            return pid_aw_pkg::S32_MIN;
        end else begin
            return pid_aw_pkg::S32_MAX;
        end
    endfunction

    // symmetric clamp, returns {hit, value}
    function automatic logic [W:0] clamp_sym(
        input logic signed [W+1:0]                  v,
        input logic [pid_aw_pkg::LIMIT_W-1:0]       lim
    );
        logic signed [W+1:0] lim_p;
        logic signed [W+1:0] lim_n;
        lim_p = $signed({3'b000, lim});
        lim_n = -lim_p;
        if (v > lim_p) begin
            return {1'b1, lim_p[W-1:0]};
        end else if (v < lim_n) begin
            return {1'b1, lim_n[W-1:0]};
        end else begin
            return {1'b0, v[W-1:0]};
        end
    endfunction

    // config registers
    logic signed [W-1:0]                    r_prop_gain;
    logic signed [W-1:0]                    r_integ_gain;
    logic signed [W-1:0]                    r_deriv_gain;
    logic [pid_aw_pkg::LIMIT_W-1:0]         r_integ_limit;
    logic [pid_aw_pkg::LIMIT_W-1:0]         r_out_limit;
    logic [W-1:0]                           r_time_step;

    // sequencer and datapath
    pid_aw_pkg::t_state                     r_state, n_state;
    logic signed [W-1:0]                    r_err, n_err;
    logic signed [W-1:0]                    r_integral, n_integral;
    logic signed [W-1:0]                    r_last_err, n_last_err;
    logic signed [W-1:0]                    r_p, n_p;
    logic signed [W-1:0]                    r_i, n_i;
    logic signed [W-1:0]                    r_d, n_d;
    logic signed [W-1:0]                    r_rate, n_rate;
    logic signed [W-1:0]                    r_sum, n_sum;
    logic                                   r_ihit, n_ihit;
    logic                                   r_ohit, n_ohit;
    logic                                   r_neg, n_neg;
    logic [W-1:0]                           r_rem, n_rem;
    logic [W-1:0]                           r_quo, n_quo;
    logic [pid_aw_pkg::DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic signed [2*W-1:0]                  r_prod;
    logic                                   r_out_valid, n_out_valid;
    logic signed [W-1:0]                    r_drive, n_drive;
    logic                                   r_out_clamped, n_out_clamped;
    logic                                   r_integ_clamped, n_integ_clamped;

    // shared multiplier
    logic signed [W:0]                      mul_a;
    logic signed [W:0]                      mul_b;
    logic signed [2*W+1:0]                  mul_y;

    assign mul_y = mul_a * mul_b;

    assign o_ready         = (r_state == pid_aw_pkg::S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_drive         = r_drive;
    assign o_out_clamped   = r_out_clamped;
    assign o_integ_clamped = r_integ_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_integ_limit <= '1;
            r_out_limit   <= '1;
            r_time_step   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                pid_aw_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_wdata;
                pid_aw_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_wdata;
                pid_aw_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_wdata;
                pid_aw_pkg::CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_wdata[pid_aw_pkg::LIMIT_W-1:0];
                pid_aw_pkg::CFG_OUT_LIMIT:   r_out_limit   <= i_cfg_wdata[pid_aw_pkg::LIMIT_W-1:0];
                pid_aw_pkg::CFG_TIME_STEP:   r_time_step   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pid_aw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_last_err  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integral  <= n_integral;
            r_last_err  <= n_last_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err           <= n_err;
        r_p             <= n_p;
        r_i             <= n_i;
        r_d             <= n_d;
        r_rate          <= n_rate;
        r_sum           <= n_sum;
        r_ihit          <= n_ihit;
        r_ohit          <= n_ohit;
        r_neg           <= n_neg;
        r_rem           <= n_rem;
        r_quo           <= n_quo;
        r_cnt           <= n_cnt;
        r_prod          <= mul_y[2*W-1:0];
        r_drive         <= n_drive;
        r_out_clamped   <= n_out_clamped;
        r_integ_clamped <= n_integ_clamped;
    end

    always_comb begin
        logic signed [W:0]    diff_in;
        logic signed [W:0]    diff_d;
        logic [W:0]           abs_d;
        logic signed [W+1:0]  acc_sum;
        logic signed [W+1:0]  pid_sum;
        logic [W:0]           clamped;
        logic [W:0]           rem2;
        logic [W:0]           ts_ext;
        logic signed [2*W-1:0] shifted;

        n_state         = r_state;
        n_err           = r_err;
        n_integral      = r_integral;
        n_last_err      = r_last_err;
        n_p             = r_p;
        n_i             = r_i;
        n_d             = r_d;
        n_rate          = r_rate;
        n_sum           = r_sum;
        n_ihit          = r_ihit;
        n_ohit          = r_ohit;
        n_neg           = r_neg;
        n_rem           = r_rem;
        n_quo           = r_quo;
        n_cnt           = r_cnt;
        n_drive         = r_drive;
        n_out_clamped   = r_out_clamped;
        n_integ_clamped = r_integ_clamped;
        n_out_valid     = r_out_valid && !i_ready;
        mul_a           = '0;
        mul_b           = '0;

        diff_in = {i_target[W-1], i_target} - {i_measured[W-1], i_measured};
        diff_d  = {r_err[W-1], r_err} - {r_last_err[W-1], r_last_err};
        abs_d   = diff_d[W] ? -diff_d : diff_d;
        acc_sum = {{2{r_integral[W-1]}}, r_integral}
                + {{2{r_prod[2*W-1]}}, r_prod[2*W-1:W]};
        pid_sum = {{2{r_p[W-1]}}, r_p} + {{2{r_i[W-1]}}, r_i}
                + {{2{r_d[W-1]}}, r_d};
        clamped = '0;
        rem2    = {r_rem, 1'b0};
        ts_ext  = {1'b0, r_time_step};
        shifted = r_prod >>> pid_aw_pkg::FRAC_BITS;

        case (r_state)
            pid_aw_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_mode) begin
                        n_integral = '0;
                        n_last_err = '0;
                        n_sum      = '0;
                        n_ohit     = 1'b0;
                        n_ihit     = 1'b0;
                        n_state    = pid_aw_pkg::S_DONE;
                    end else begin
                        if (diff_in[W] != diff_in[W-1]) begin
                            n_err = diff_in[W] ? pid_aw_pkg::S32_MIN : pid_aw_pkg::S32_MAX;
                        end else begin
                            n_err = diff_in[W-1:0];
                        end
                        n_state = pid_aw_pkg::S_MUL_P;
                    end
                end
            end
            pid_aw_pkg::S_MUL_P: begin
                mul_a   = {r_prop_gain[W-1], r_prop_gain};
                mul_b   = {r_err[W-1], r_err};
                n_state = pid_aw_pkg::S_MUL_DT;
            end
            pid_aw_pkg::S_MUL_DT: begin
                n_p     = sat64(shifted);
                mul_a   = {r_err[W-1], r_err};
                mul_b   = {1'b0, r_time_step};
                n_state = pid_aw_pkg::S_ACC;
            end
            pid_aw_pkg::S_ACC: begin
                // floor(e*dt / 2^32) is the top word of the product
                clamped    = clamp_sym(acc_sum, r_integ_limit);
                n_integral = clamped[W-1:0];
                n_ihit     = clamped[W];
                n_state    = pid_aw_pkg::S_MUL_I;
            end
            pid_aw_pkg::S_MUL_I: begin
                mul_a   = {r_integ_gain[W-1], r_integ_gain};
                mul_b   = {r_integral[W-1], r_integral};
                n_state = pid_aw_pkg::S_D_SETUP;
            end
            pid_aw_pkg::S_D_SETUP: begin
                n_i        = sat64(shifted);
                n_last_err = r_err;
                n_neg      = diff_d[W];
                n_rem      = abs_d[W-1:0];
                n_quo      = '0;
                n_cnt      = '0;
                if (r_time_step <= pid_aw_pkg::DT_MIN_RAW) begin
                    n_d     = '0;
                    n_state = pid_aw_pkg::S_SUM;
                end else if (abs_d >= ts_ext) begin
                    // quotient is at least 2^32: rate saturates
                    n_rate  = diff_d[W] ? pid_aw_pkg::S32_MIN : pid_aw_pkg::S32_MAX;
                    n_state = pid_aw_pkg::S_MUL_D;
                end else begin
                    n_state = pid_aw_pkg::S_DIV;
                end
            end
            pid_aw_pkg::S_DIV: begin
                // restoring divide of |diff|*2^32 by time_step, one bit a cycle
                if (rem2 >= ts_ext) begin
                    n_rem = W'(rem2 - ts_ext);
                    n_quo = {r_quo[W-2:0], 1'b1};
                end else begin
                    n_rem = rem2[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == pid_aw_pkg::DIV_CNT_W'(pid_aw_pkg::DIV_STEPS - 1)) begin
                    n_state = pid_aw_pkg::S_RATE;
                end
            end
            pid_aw_pkg::S_RATE: begin
                if (!r_neg) begin
                    n_rate = r_quo[W-1] ? pid_aw_pkg::S32_MAX : r_quo;
                end else if (r_quo[W-1] && (|r_quo[W-2:0])) begin
                    n_rate = pid_aw_pkg::S32_MIN;
                end else begin
                    n_rate = -r_quo;
                end
                n_state = pid_aw_pkg::S_MUL_D;
            end
            pid_aw_pkg::S_MUL_D: begin
                mul_a   = {r_deriv_gain[W-1], r_deriv_gain};
                mul_b   = {r_rate[W-1], r_rate};
                n_state = pid_aw_pkg::S_D_TERM;
            end
            pid_aw_pkg::S_D_TERM: begin
                n_d     = sat64(shifted);
                n_state = pid_aw_pkg::S_SUM;
            end
            pid_aw_pkg::S_SUM: begin
                clamped = clamp_sym(pid_sum, r_out_limit);
                n_sum   = clamped[W-1:0];
                n_ohit  = clamped[W];
                n_state = pid_aw_pkg::S_DONE;
            end
            pid_aw_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_drive         = r_sum;
                    n_out_clamped   = r_ohit;
                    n_integ_clamped = r_ihit;
                    n_out_valid     = 1'b1;
                    n_state         = pid_aw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pid_aw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* dv/pid_controller_anti_windup_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_unit_test
// Self-checking bench for the PID step engine. Input words are queued per
// configuration phase and checked against a cycle-free controller model.
// The phases run short directed corners, then random or extreme gain, limit
// and step settings, with bursty input and a patterned, stalling output.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup_unit_test;

    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [31:0] ONE_Q        = 32'h0001_0000;
    localparam logic [31:0] POS_FULL     = 32'h7fff_ffff;
    localparam logic [31:0] NEG_FULL     = 32'h8000_0000;
    localparam logic [31:0] DT_ONE_MS    = 32'd4294967;
    localparam int          PHASE_WORDS  = 200;
    localparam int          RANDOM_PHASES = 8;
    localparam int          LONG_HOLD    = 400;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] target;
        logic signed [31:0] measured;
    } t_pid_sample;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               out_hit;
        logic               integ_hit;
    } t_drive_result;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } t_rx_style;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [pid_aw_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [pid_aw_pkg::DATA_W-1:0]     i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic        i_mode      = 1'b0;
    logic signed [pid_aw_pkg::DATA_W-1:0] i_target   = '0;
    logic signed [pid_aw_pkg::DATA_W-1:0] i_measured = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic signed [pid_aw_pkg::DATA_W-1:0] o_drive;
    logic        o_out_clamped;
    logic        o_integ_clamped;

    pid_controller_anti_windup_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_target        (i_target),
        .i_measured      (i_measured),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive         (o_drive),
        .o_out_clamped   (o_out_clamped),
        .o_integ_clamped (o_integ_clamped)
    );

    always #5 i_clk = ~i_clk;

    // controller model: register copies and loop state
    logic signed [31:0] prop_k    = '0;
    logic signed [31:0] integ_k   = '0;
    logic signed [31:0] deriv_k   = '0;
    logic [30:0]        integ_lim = '1;
    logic [30:0]        out_lim   = '1;
    logic [31:0]        dt        = '0;
    longint             integ_acc = 0;
    longint             prev_err  = 0;

    t_pid_sample   pending_samples[$];
    t_drive_result drive_expect_q[$];
    t_pid_sample   cur_sample;

    int samples_queued = 0;
    int samples_taken  = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    int        burst_left = 0;
    int        gap_left   = 0;
    bit        drain_hold = 1'b0;
    logic      long_hold_req  = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_left  = 0;
    int        style_left = 0;
    int        rx_tick    = 0;
    t_rx_style stall_style = RX_STREAM;
    logic      next_ready;
    t_drive_result want;
    logic signed [31:0] drift_base = '0;

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_gain(longint g, longint x);
        return sat_s32((g * x) >>> pid_aw_pkg::FRAC_BITS);
    endfunction

    function automatic longint clamp_sym(longint v, longint lim, output logic hit);
        hit = 1'b0;
        if (v > lim) begin
            hit = 1'b1;
            return lim;
        end
        if (v < -lim) begin
            hit = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic t_drive_result step_controller(t_pid_sample s);
        t_drive_result r;
        longint err, p_term, i_term, d_term, slice, diff, rate, sum;
        longint unsigned mag, quo, dt64;
        logic hit;
        r = '0;
        if (s.mode == MODE_CLEAR) begin
            integ_acc = 0;
            prev_err  = 0;
            return r;
        end
        err    = sat_s32(longint'($signed(s.target)) - longint'($signed(s.measured)));
        p_term = scale_gain(prop_k, err);
        slice  = (err * longint'({32'b0, dt})) >>> 32;
        integ_acc = clamp_sym(integ_acc + slice, longint'({33'b0, integ_lim}), hit);
        r.integ_hit = hit;
        i_term = scale_gain(integ_k, integ_acc);
        d_term = 0;
        // rate is |diff| * 2^32 / dt, rounded toward zero
        if (dt > pid_aw_pkg::DT_MIN_RAW) begin
            diff = err - prev_err;
            mag  = (diff < 0) ? -diff : diff;
            dt64 = {32'b0, dt};
            quo  = ((mag / dt64) << 32) + (((mag % dt64) << 32) / dt64);
            rate = (diff < 0) ? -longint'(quo) : longint'(quo);
            d_term = scale_gain(deriv_k, sat_s32(rate));
        end
        prev_err = err;
        sum = clamp_sym(p_term + i_term + d_term, longint'({33'b0, out_lim}), hit);
        r.drive   = sum[31:0];
        r.out_hit = hit;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic write_reg(pid_aw_pkg::t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            pid_aw_pkg::CFG_PROP_GAIN:   prop_k    = val;
            pid_aw_pkg::CFG_INTEG_GAIN:  integ_k   = val;
            pid_aw_pkg::CFG_DERIV_GAIN:  deriv_k   = val;
            pid_aw_pkg::CFG_INTEG_LIMIT: integ_lim = val[30:0];
            pid_aw_pkg::CFG_OUT_LIMIT:   out_lim   = val[30:0];
            pid_aw_pkg::CFG_TIME_STEP:   dt        = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_controller(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                  logic [31:0] ilim, logic [31:0] olim, logic [31:0] step);
        write_reg(pid_aw_pkg::CFG_PROP_GAIN, kp);
        write_reg(pid_aw_pkg::CFG_INTEG_GAIN, ki);
        write_reg(pid_aw_pkg::CFG_DERIV_GAIN, kd);
        write_reg(pid_aw_pkg::CFG_INTEG_LIMIT, ilim);
        write_reg(pid_aw_pkg::CFG_OUT_LIMIT, olim);
        write_reg(pid_aw_pkg::CFG_TIME_STEP, step);
    endtask

    task automatic queue_sample(logic mode, logic [31:0] tgt, logic [31:0] meas);
        t_pid_sample s;
        s.mode     = mode;
        s.target   = tgt;
        s.measured = meas;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // every queued word taken and every result back
    task automatic wait_idle();
        wait (samples_taken == samples_queued && results_seen == samples_queued);
    endtask

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return POS_FULL;
            1:       return NEG_FULL;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return corner_value();
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // bit 31 of a limit write is ignored, so it is randomized too
    function automatic logic [31:0] pick_limit();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h0;
            1:       v = POS_FULL;
            2:       v = $urandom;
            default: v = $urandom_range(1, 1 << 26);
        endcase
        v[31] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return pid_aw_pkg::DT_MIN_RAW;
            2:       return pid_aw_pkg::DT_MIN_RAW + 1;
            3:       return 32'hffff_ffff;
            4:       return $urandom;
            5:       return $urandom_range(0, 8000);
            default: return DT_ONE_MS + $urandom_range(0, 1 << 24);
        endcase
    endfunction

    // mostly a slowly drifting loop so the integral and D term stay meaningful
    task automatic queue_random_sample();
        int pick;
        logic [31:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            queue_sample(MODE_CLEAR, $urandom, $urandom);
        end else if (pick < 20) begin
            queue_sample(MODE_STEP, $urandom, $urandom);
        end else if (pick < 26) begin
            queue_sample(MODE_STEP, corner_value(), corner_value());
        end else begin
            drift_base = drift_base + (int'($urandom_range(0, 1 << 17)) - (1 << 16));
            tgt = drift_base + $urandom_range(0, 1 << 16);
            queue_sample(MODE_STEP, tgt,
                         tgt - (int'($urandom_range(0, 1 << 19)) - (1 << 18)));
        end
    endtask

    // sender: bursts of words with random gaps, occasional full drain
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                drive_expect_q.push_back(step_controller(cur_sample));
                samples_taken++;
                if ($urandom_range(0, 199) == 0)
                    drain_hold = 1'b1;
            end
            if (drain_hold && results_seen == samples_taken)
                drain_hold = 1'b0;
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (drain_hold || pending_samples.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    cur_sample = pending_samples.pop_front();
                    i_valid    <= 1'b1;
                    i_mode     <= cur_sample.mode;
                    i_target   <= cur_sample.target;
                    i_measured <= cur_sample.measured;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // receiver: checks each result word, stalls on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (drive_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word drive=%h", o_drive));
                end else begin
                    want = drive_expect_q.pop_front();
                    if (o_drive !== want.drive)
                        report_mismatch($sformatf("drive got %h want %h",
                                                  o_drive, want.drive));
                    if (o_out_clamped !== want.out_hit)
                        report_mismatch($sformatf("out_clamped got %b want %b",
                                                  o_out_clamped, want.out_hit));
                    if (o_integ_clamped !== want.integ_hit)
                        report_mismatch($sformatf("integ_clamped got %b want %b",
                                                  o_integ_clamped, want.integ_hit));
                    results_seen++;
                end
            end
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (style_left == 0) begin
                stall_style = t_rx_style'($urandom_range(0, 3));
                style_left  = $urandom_range(16, 128);
            end else begin
                style_left--;
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case (stall_style)
                    RX_STREAM:      next_ready = 1'b1;
                    RX_COIN:        next_ready = 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: next_ready = (rx_tick % 4 == 0);
                    default:        next_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
            i_ready <= next_ready;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: all gains zero, so every drive is zero
        queue_sample(MODE_STEP, 32'd100 << 16, 32'd50 << 16);
        queue_sample(MODE_STEP, POS_FULL, NEG_FULL);
        wait_idle();

        // moderate gains, 1 ms step; error and rate saturation both ways
        set_controller(ONE_Q, ONE_Q >> 1, ONE_Q >> 2, 32'hffff_ffff, POS_FULL, DT_ONE_MS);
        queue_sample(MODE_STEP, 32'd10 << 16, 32'd2 << 16);
        queue_sample(MODE_STEP, 32'd10 << 16, 32'd2 << 16);
        queue_sample(MODE_STEP, POS_FULL, NEG_FULL);
        queue_sample(MODE_STEP, NEG_FULL, POS_FULL);
        queue_sample(MODE_STEP, 32'h0, 32'h0);
        queue_sample(MODE_CLEAR, POS_FULL, NEG_FULL);
        queue_sample(MODE_STEP, 32'hffff_ffff, 32'h0);
        queue_sample(MODE_STEP, 32'h1, 32'h0);
        wait_idle();

        // step at the 1 us threshold: no D term; zero integral limit
        set_controller(POS_FULL, NEG_FULL, POS_FULL, 32'h0, ONE_Q, pid_aw_pkg::DT_MIN_RAW);
        queue_sample(MODE_STEP, 32'd5 << 16, 32'h0);
        queue_sample(MODE_STEP, -(32'd5 << 16), 32'h0);
        queue_sample(MODE_STEP, 32'h0, 32'h0);
        wait_idle();

        // shortest step that divides; zero output limit
        set_controller(ONE_Q, ONE_Q, POS_FULL, 32'h100, 32'h0, pid_aw_pkg::DT_MIN_RAW + 1);
        queue_sample(MODE_STEP, 32'h1, 32'h0);
        queue_sample(MODE_STEP, NEG_FULL, 32'h0);
        queue_sample(MODE_STEP, POS_FULL, NEG_FULL);
        wait_idle();

        // most negative gains, longest step
        set_controller(NEG_FULL, NEG_FULL, NEG_FULL, POS_FULL, POS_FULL, 32'hffff_ffff);
        queue_sample(MODE_STEP, POS_FULL, NEG_FULL);
        queue_sample(MODE_STEP, NEG_FULL, POS_FULL);
        queue_sample(MODE_CLEAR, 32'h0, 32'h0);
        queue_sample(MODE_STEP, ONE_Q, 32'h0);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 3)
                set_controller(POS_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL, 32'hffff_ffff);
            else if (phase == 6)
                set_controller(NEG_FULL, NEG_FULL, NEG_FULL, 32'h0, 32'h0, 32'h0);
            else
                set_controller(pick_gain(), pick_gain(), pick_gain(),
                               pick_limit(), pick_limit(), pick_step());
            for (int n = 0; n < PHASE_WORDS; n++)
                queue_random_sample();
            // long output stall while the sender keeps offering
            if (phase == 2)
                long_hold_req <= 1'b1;
            wait_idle();
        end

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("pid_controller_anti_windup_unit verification clean");
        else
            $display("pid_controller_anti_windup_unit verification failed");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("pid_controller_anti_windup_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
src/pid_aw_pkg.sv
src/pid_controller_anti_windup_unit.sv
dv/pid_controller_anti_windup_unit_test.sv
